// ===== sv/wavhp_pkg.sv =====
// shared types, codes and constants of the wav header parser
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_LEN  = 32'd16;
  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [31:0] HEAD_LEN = 32'd12;
  localparam logic [31:0] TAIL_LEN = 32'd28;
  localparam logic [31:0] WORD_LEN = 32'd4;
  localparam logic [31:0] OFF_MAX  = 32'hFFFF_FFFF - TAIL_LEN - WORD_LEN;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_SIG    = 4'd1,
    ST_NOT_WAVE   = 4'd2,
    ST_FMT_SIZE   = 4'd3,
    ST_NOT_PCM    = 4'd4,
    ST_NO_DATA    = 4'd5,
    ST_TRUNCATED  = 4'd6,
    ST_ZERO_FRAME = 4'd7,
    ST_OFF_OVF    = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    PH_SIG,
    PH_SIZE,
    PH_WAVE,
    PH_SCAN,
    PH_FMTSIZE,
    PH_FORMAT,
    PH_CHAN,
    PH_RATE,
    PH_BRATE,
    PH_ALIGN,
    PH_BITS,
    PH_DMARK,
    PH_DSIZE,
    PH_DIVIDE,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_CHAN,
    LD_RATE,
    LD_BRATE,
    LD_ALIGN,
    LD_BITS,
    LD_DSIZE
  } load_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        big_endian;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] chunk_len;
    logic [31:0] sample_count;
    logic [31:0] audio_start;
  } out_item_t;

  typedef struct packed {
    logic    shift;
    load_t   load;
    logic    set_endian;
    logic    endian_val;
    logic    off_init;
    logic    off_inc;
    logic    emit;
    logic    emit_fields;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic is_riff;
    logic is_rifx;
    logic is_wave;
    logic is_fmt;
    logic is_data;
    logic fmt16;
    logic pcm;
    logic off_ovf;
    logic frame_zero;
    logic div_busy;
    logic out_full;
  } sts_t;

endpackage

// ===== sv/wavhp_ctrl.sv =====
// parse sequencer: phase and byte position, issues datapath commands
module wavhp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               first_byte,
  input  logic               end_of_file,
  input  wavhp_pkg::sts_t    sts,
  output wavhp_pkg::cmd_t    cmd
);
  import wavhp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] bw_r, bw_nxt;

  phase_t     ph;
  logic [1:0] bw;
  logic       accept;
  logic       complete;
  logic       result;

  assign in_ready = (phase_r != PH_DIVIDE) && !sts.out_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      bw_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      bw_r    <= bw_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    bw_nxt    = bw_r;
    ph        = first_byte ? PH_SIG : phase_r;
    bw        = first_byte ? 2'd0 : bw_r;
    complete  = 1'b0;
    result    = 1'b0;
    if (phase_r == PH_DIVIDE) begin
      if (sts.frame_zero || !sts.div_busy) begin
        cmd.emit        = 1'b1;
        cmd.emit_fields = 1'b1;
        cmd.code        = sts.frame_zero ? ST_ZERO_FRAME : ST_OK;
        phase_nxt       = PH_DONE;
      end
    end else if (accept && ph != PH_DONE) begin
      cmd.shift = 1'b1;
      phase_nxt = ph;
      if (ph inside {PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS}) begin
        complete = (bw == 2'd1);
      end else begin
        complete = (bw == 2'd3);
      end
      if (!complete) begin
        bw_nxt = bw + 2'd1;
      end else begin
        bw_nxt = '0;
        case (ph)
          PH_SIG: begin
            if (sts.is_riff || sts.is_rifx) begin
              cmd.set_endian = 1'b1;
              cmd.endian_val = sts.is_rifx;
              phase_nxt      = PH_SIZE;
            end else begin
              result   = 1'b1;
              cmd.code = ST_BAD_SIG;
            end
          end
          PH_SIZE: phase_nxt = PH_WAVE;
          PH_WAVE: begin
            if (sts.is_wave) begin
              cmd.off_init = 1'b1;
              phase_nxt    = PH_SCAN;
            end else begin
              result   = 1'b1;
              cmd.code = ST_NOT_WAVE;
            end
          end
          PH_SCAN: begin
            if (sts.off_ovf) begin
              result   = 1'b1;
              cmd.code = ST_OFF_OVF;
            end else begin
              cmd.off_inc = 1'b1;
              if (sts.is_fmt) begin
                phase_nxt = PH_FMTSIZE;
              end
            end
          end
          PH_FMTSIZE: begin
            if (sts.fmt16) begin
              phase_nxt = PH_FORMAT;
            end else begin
              result   = 1'b1;
              cmd.code = ST_FMT_SIZE;
            end
          end
          PH_FORMAT: begin
            if (sts.pcm) begin
              phase_nxt = PH_CHAN;
            end else begin
              result   = 1'b1;
              cmd.code = ST_NOT_PCM;
            end
          end
          PH_CHAN: begin
            cmd.load  = LD_CHAN;
            phase_nxt = PH_RATE;
          end
          PH_RATE: begin
            cmd.load  = LD_RATE;
            phase_nxt = PH_BRATE;
          end
          PH_BRATE: begin
            cmd.load  = LD_BRATE;
            phase_nxt = PH_ALIGN;
          end
          PH_ALIGN: begin
            cmd.load  = LD_ALIGN;
            phase_nxt = PH_BITS;
          end
          PH_BITS: begin
            cmd.load  = LD_BITS;
            phase_nxt = PH_DMARK;
          end
          PH_DMARK: begin
            if (sts.is_data) begin
              phase_nxt = PH_DSIZE;
            end else begin
              result   = 1'b1;
              cmd.code = ST_NO_DATA;
            end
          end
          PH_DSIZE: begin
            cmd.load  = LD_DSIZE;
            phase_nxt = PH_DIVIDE;
          end
          default: phase_nxt = ph;
        endcase
      end
      if (!result && end_of_file && phase_nxt != PH_DIVIDE) begin
        result   = 1'b1;
        cmd.code = ST_TRUNCATED;
      end
      if (result) begin
        cmd.emit  = 1'b1;
        phase_nxt = PH_DONE;
      end
    end
  end

endmodule

// ===== sv/wavhp_dp.sv =====
// word assembly, field registers, frame divider and result register
module wavhp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wavhp_pkg::in_item_t  in_data,
  input  wavhp_pkg::cmd_t      cmd,
  output wavhp_pkg::sts_t      sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wavhp_pkg::out_item_t out_data
);
  import wavhp_pkg::*;

  logic [31:0] ws_r;
  logic        endian_r;
  logic [15:0] chan_r;
  logic [31:0] rate_r;
  logic [31:0] brate_r;
  logic [15:0] align_r;
  logic [15:0] bits_r;
  logic [31:0] dsize_r;
  logic [31:0] off_r;
  logic [31:0] prod_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [4:0]  cnt_r;
  logic        div_busy_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [31:0] ws_base;
  logic        endian_base;
  logic [31:0] w;
  logic [31:0] v32;
  logic [15:0] v16;
  logic [28:0] frame;
  logic [32:0] trial;
  logic        fits;
  logic        start_div;

  assign ws_base     = in_data.first_byte ? '0 : ws_r;
  assign endian_base = in_data.first_byte ? 1'b0 : endian_r;
  assign w           = {ws_base[23:0], in_data.data_byte};
  assign v32         = endian_base ? w : {w[7:0], w[15:8], w[23:16], w[31:24]};
  assign v16         = endian_base ? w[15:0] : {w[7:0], w[15:8]};
  assign frame       = prod_r[31:3];
  assign trial       = {rem_r, quo_r[31]};
  assign fits        = trial >= {4'b0, frame};
  assign start_div   = (cmd.load == LD_DSIZE) && !sts.frame_zero;

  assign sts.is_riff    = (w == TAG_RIFF);
  assign sts.is_rifx    = (w == TAG_RIFX);
  assign sts.is_wave    = (w == TAG_WAVE);
  assign sts.is_fmt     = (w == TAG_FMT);
  assign sts.is_data    = (w == TAG_DATA);
  assign sts.fmt16      = (v32 == FMT_LEN);
  assign sts.pcm        = (v16 == FMT_PCM);
  assign sts.off_ovf    = (off_r > OFF_MAX);
  assign sts.frame_zero = (frame == '0);
  assign sts.div_busy   = div_busy_r;
  assign sts.out_full   = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      ws_r <= w;
      if (in_data.first_byte) begin
        endian_r <= 1'b0;
        chan_r   <= '0;
        rate_r   <= '0;
        brate_r  <= '0;
        align_r  <= '0;
        bits_r   <= '0;
        dsize_r  <= '0;
        off_r    <= '0;
      end
    end
    if (cmd.set_endian) begin
      endian_r <= cmd.endian_val;
    end
    if (cmd.off_init) begin
      off_r <= HEAD_LEN;
    end else if (cmd.off_inc) begin
      off_r <= off_r + WORD_LEN;
    end
    case (cmd.load)
      LD_CHAN:  chan_r  <= v16;
      LD_RATE:  rate_r  <= v32;
      LD_BRATE: brate_r <= v32;
      LD_ALIGN: align_r <= v16;
      LD_BITS:  bits_r  <= v16;
      LD_DSIZE: dsize_r <= v32;
      default: ;
    endcase
    prod_r <= 32'(chan_r) * 32'(bits_r);
    if (start_div) begin
      quo_r <= v32;
      rem_r <= '0;
    end else if (div_busy_r) begin
      rem_r <= fits ? 32'(trial - {4'b0, frame}) : trial[31:0];
      quo_r <= {quo_r[30:0], fits};
    end
    if (cmd.emit) begin
      out_r.status <= cmd.code;
      if (cmd.emit_fields) begin
        out_r.big_endian      <= endian_r;
        out_r.channel_count   <= chan_r;
        out_r.rate_hz         <= rate_r;
        out_r.byte_rate       <= brate_r;
        out_r.block_align     <= align_r;
        out_r.bits_per_sample <= bits_r;
        out_r.chunk_len       <= dsize_r;
        out_r.sample_count    <= (cmd.code == ST_ZERO_FRAME) ? '0 : quo_r;
        out_r.audio_start     <= off_r + TAIL_LEN;
      end else begin
        out_r.big_endian      <= 1'b0;
        out_r.channel_count   <= '0;
        out_r.rate_hz         <= '0;
        out_r.byte_rate       <= '0;
        out_r.block_align     <= '0;
        out_r.bits_per_sample <= '0;
        out_r.chunk_len       <= '0;
        out_r.sample_count    <= '0;
        out_r.audio_start     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start_div) begin
        div_busy_r <= 1'b1;
        cnt_r      <= '0;
      end else if (div_busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == '1) begin
          div_busy_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r) else $error("result overwritten while waiting");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_div |-> !div_busy_r) else $error("divider restarted while busy");
  a_no_byte_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> !cmd.shift) else $error("byte taken during division");
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(div_busy_r) |-> $past(cnt_r) == '1) else $error("division cut short");

endmodule

// ===== sv/wav_header_parser.sv =====
// top level of the wav header parser
//
//  channel | ports                         | item
//  --------+-------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_data   | one file byte with marks
//  result  | out_valid, out_ready, out_data| header fields and status
//
// one byte is taken per cycle while no result waits in the output register and no divide runs
// a complete header starts a restoring divide for the sample count, and input is
// held off until the result is loaded (a zero frame skips the divide)
// in_ready stays low while a result waits for out_ready
// rst_n is synchronous; after reset the parser awaits a signature
module wav_header_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wavhp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wavhp_pkg::out_item_t out_data
);
  import wavhp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wavhp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first_byte  (in_data.first_byte),
    .end_of_file (in_data.end_of_file),
    .sts         (sts),
    .cmd         (cmd)
  );

  wavhp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/wav_header_parser_tb.sv =====
// self-checking testbench of the wav header parser: predicted results, byte streams, random stalls
module wav_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wavhp_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int TARGET_BYTES   = 1100;
  localparam int TAIL_WAIT      = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    FL_CLEAN,
    FL_BAD_SIG,
    FL_NOT_WAVE,
    FL_FMT_SIZE,
    FL_NOT_PCM,
    FL_NO_DATA,
    FL_ZERO_FRAME,
    FL_CUT,
    FL_RESTART,
    FL_NOISE
  } flaw_t;

  class header_board;
    out_item_t   pending_headers[$];
    phase_t      phase;
    int          byte_pos;
    logic [31:0] shift_word;
    logic        big;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [31:0] dsize;
    logic [31:0] scan_offset;
    bit          done;
    int          mismatches;
    int          results_predicted;
    int          results_checked;
    int          status_hits[16];

    function new();
      clear();
    endfunction

    function void clear();
      phase       = PH_SIG;
      byte_pos    = 0;
      shift_word  = '0;
      big         = 1'b0;
      chans       = '0;
      align       = '0;
      bits        = '0;
      rate        = '0;
      brate       = '0;
      dsize       = '0;
      scan_offset = '0;
      done        = 1'b0;
    endfunction

    function void post_error(status_t code);
      out_item_t r;
      r = '0;
      r.status = code;
      pending_headers.push_back(r);
      results_predicted++;
      done = 1'b1;
    endfunction

    function void take_byte(in_item_t it);
      logic [31:0] w;
      logic [31:0] v32;
      logic [15:0] v16;
      logic [31:0] frame;
      int          need;
      out_item_t   r;
      if (it.first_byte) clear();
      if (done) return;
      shift_word = {shift_word[23:0], it.data_byte};
      need = (phase inside {PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS}) ? 2 : 4;
      if (byte_pos + 1 < need) begin
        byte_pos++;
        if (it.end_of_file) post_error(ST_TRUNCATED);
        return;
      end
      byte_pos = 0;
      w = shift_word;
      v32 = big ? w : {w[7:0], w[15:8], w[23:16], w[31:24]};
      v16 = big ? w[15:0] : {w[7:0], w[15:8]};
      case (phase)
        PH_SIG: begin
          if (w == TAG_RIFF) big = 1'b0;
          else if (w == TAG_RIFX) big = 1'b1;
          else begin
            post_error(ST_BAD_SIG);
            return;
          end
          phase = PH_SIZE;
        end
        PH_SIZE: phase = PH_WAVE;
        PH_WAVE: begin
          if (w != TAG_WAVE) begin
            post_error(ST_NOT_WAVE);
            return;
          end
          scan_offset = HEAD_LEN;
          phase = PH_SCAN;
        end
        PH_SCAN: begin
          if ({1'b0, scan_offset} + {1'b0, WORD_LEN} + {1'b0, TAIL_LEN} > {1'b0, 32'hFFFF_FFFF})
          begin
            post_error(ST_OFF_OVF);
            return;
          end
          scan_offset = scan_offset + WORD_LEN;
          if (w == TAG_FMT) phase = PH_FMTSIZE;
        end
        PH_FMTSIZE: begin
          if (v32 != FMT_LEN) begin
            post_error(ST_FMT_SIZE);
            return;
          end
          phase = PH_FORMAT;
        end
        PH_FORMAT: begin
          if (v16 != FMT_PCM) begin
            post_error(ST_NOT_PCM);
            return;
          end
          phase = PH_CHAN;
        end
        PH_CHAN: begin
          chans = v16;
          phase = PH_RATE;
        end
        PH_RATE: begin
          rate = v32;
          phase = PH_BRATE;
        end
        PH_BRATE: begin
          brate = v32;
          phase = PH_ALIGN;
        end
        PH_ALIGN: begin
          align = v16;
          phase = PH_BITS;
        end
        PH_BITS: begin
          bits = v16;
          phase = PH_DMARK;
        end
        PH_DMARK: begin
          if (w != TAG_DATA) begin
            post_error(ST_NO_DATA);
            return;
          end
          phase = PH_DSIZE;
        end
        PH_DSIZE: begin
          dsize = v32;
          frame = ({16'd0, chans} * {16'd0, bits}) >> 3;
          r = '0;
          r.status          = (frame == 0) ? ST_ZERO_FRAME : ST_OK;
          r.big_endian      = big;
          r.channel_count   = chans;
          r.rate_hz         = rate;
          r.byte_rate       = brate;
          r.block_align     = align;
          r.bits_per_sample = bits;
          r.chunk_len       = dsize;
          r.sample_count    = (frame == 0) ? 32'd0 : dsize / frame;
          r.audio_start     = scan_offset + TAIL_LEN;
          pending_headers.push_back(r);
          results_predicted++;
          done = 1'b1;
          return;
        end
        default: ;
      endcase
      if (it.end_of_file) post_error(ST_TRUNCATED);
    endfunction

    function void diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: %s expected %0h got %0h", results_checked, name, want, got);
      end
    endfunction

    function void check_header(out_item_t got);
      out_item_t want;
      if (pending_headers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing expected: status %0h", got.status);
        return;
      end
      want = pending_headers.pop_front();
      results_checked++;
      status_hits[want.status]++;
      diff("status", 32'(want.status), 32'(got.status));
      diff("big_endian", 32'(want.big_endian), 32'(got.big_endian));
      diff("channel_count", 32'(want.channel_count), 32'(got.channel_count));
      diff("rate_hz", want.rate_hz, got.rate_hz);
      diff("byte_rate", want.byte_rate, got.byte_rate);
      diff("block_align", 32'(want.block_align), 32'(got.block_align));
      diff("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
      diff("chunk_len", want.chunk_len, got.chunk_len);
      diff("sample_count", want.sample_count, got.sample_count);
      diff("audio_start", want.audio_start, got.audio_start);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  header_board board = new();
  logic [7:0]  img[$];
  bit          calm = 1'b0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          cycles = 0;
  int          hold_left = 0;
  int          holds_done = 0;

  wav_header_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.pending_headers.size());
      $display("wav_header_parser verification failed");
      $finish;
    end
  end

  // result side, with long hold-offs so the input backs up
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_header(out_data);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && board.results_checked >= (holds_done == 0 ? 3 : 12)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic eof);
    in_item_t item;
    item.data_byte   = b;
    item.first_byte  = first;
    item.end_of_file = eof;
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    board.take_byte(item);
    bytes_sent++;
  endtask

  task automatic put_val(input logic [31:0] val, input int nbytes, input logic msb_first);
    for (int k = 0; k < nbytes; k++)
      img.push_back(msb_first ? val[8 * (nbytes - 1 - k) +: 8] : val[8 * k +: 8]);
  endtask

  task automatic build_file(input flaw_t flaw, input logic big);
    logic [31:0] tag;
    logic [15:0] chans;
    logic [15:0] bits;
    int          nscan;
    img.delete();
    if (flaw == FL_NOISE) begin
      repeat ($urandom_range(1, 16)) img.push_back(8'($urandom_range(255)));
      return;
    end
    tag = big ? TAG_RIFX : TAG_RIFF;
    if (flaw == FL_BAD_SIG) tag = tag ^ (32'd1 << $urandom_range(31));
    put_val(tag, 4, 1'b1);
    put_val($urandom, 4, 1'b1);
    put_val(flaw == FL_NOT_WAVE ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE, 4, 1'b1);
    nscan = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
    repeat (nscan) put_val(($urandom_range(3) == 0) ? TAG_DATA : $urandom, 4, 1'b1);
    put_val(TAG_FMT, 4, 1'b1);
    put_val(flaw == FL_FMT_SIZE ? FMT_LEN ^ (32'd1 << $urandom_range(31)) : FMT_LEN, 4, big);
    put_val({16'd0, flaw == FL_NOT_PCM ? FMT_PCM ^ (16'd1 << $urandom_range(15)) : FMT_PCM},
            2, big);
    if (flaw == FL_ZERO_FRAME) begin
      chans = 16'($urandom_range(3));
      bits  = (chans == 0) ? pick16() : 16'($urandom_range(7 / chans));
    end else if ($urandom_range(3) == 0) begin
      chans = pick16();
      bits  = pick16();
    end else begin
      chans = 16'($urandom_range(1, 8));
      bits  = 16'(8 * $urandom_range(1, 4));
    end
    put_val({16'd0, chans}, 2, big);
    put_val(pick32(), 4, big);
    put_val(pick32(), 4, big);
    put_val({16'd0, pick16()}, 2, big);
    put_val({16'd0, bits}, 2, big);
    put_val(flaw == FL_NO_DATA ? TAG_DATA ^ (32'd1 << $urandom_range(31)) : TAG_DATA, 4, 1'b1);
    put_val(pick32(), 4, big);
  endtask

  task automatic send_file(input flaw_t flaw);
    int   stop;
    logic mark;
    stop = img.size();
    if (flaw == FL_CUT || flaw == FL_RESTART) stop = $urandom_range(1, img.size() - 1);
    mark = (flaw != FL_NOISE) || ($urandom_range(3) != 0);
    for (int i = 0; i < stop; i++) begin
      if (flaw == FL_NOISE)
        send_byte(img[i], mark && i == 0, $urandom_range(9) == 0);
      else
        send_byte(img[i], i == 0, i == stop - 1 && flaw != FL_RESTART &&
                  (flaw == FL_CUT || $urandom_range(1) == 1));
    end
    // bytes after the end, no restart mark
    repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0, $urandom_range(1) == 1);
  endtask

  initial begin
    flaw_t flaw;
    int    roll;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // bad signature with no first mark right after reset
    send_byte("R", 1'b0, 1'b0); send_byte("I", 1'b0, 1'b0);
    send_byte("F", 1'b0, 1'b0); send_byte("Z", 1'b0, 1'b0);
    // ignored until the next first mark
    send_byte(8'hFF, 1'b0, 1'b1); send_byte(8'h00, 1'b0, 1'b0);
    // one-byte file
    send_byte("R", 1'b1, 1'b1);
    // big endian signature, then not wave
    send_byte("R", 1'b1, 1'b0); send_byte("I", 1'b0, 1'b0);
    send_byte("F", 1'b0, 1'b0); send_byte("X", 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0); send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0); send_byte(8'hFF, 1'b0, 1'b0);
    send_byte("W", 1'b0, 1'b0); send_byte("A", 1'b0, 1'b0);
    send_byte("V", 1'b0, 1'b0); send_byte("X", 1'b0, 1'b0);
    // restart mid word, then end of file on the byte that completes the signature
    send_byte("R", 1'b1, 1'b0); send_byte("I", 1'b0, 1'b0);
    send_byte("R", 1'b1, 1'b0); send_byte("I", 1'b0, 1'b0);
    send_byte("F", 1'b0, 1'b0); send_byte("F", 1'b0, 1'b1);

    while (bytes_sent < TARGET_BYTES) begin
      calm = (files_sent >= 10 && files_sent < 17);
      roll = $urandom_range(99);
      flaw = (roll < 40) ? FL_CLEAN : flaw_t'(int'(FL_BAD_SIG) + (roll - 40) % 9);
      build_file(flaw, $urandom_range(1) == 1);
      send_file(flaw);
      files_sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending_headers.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (board.pending_headers.size() != 0) board.mismatches++;

    $display("%0d bytes in %0d random files plus directed streams, %0d of %0d results checked",
             bytes_sent, files_sent, board.results_checked, board.results_predicted);
    $display("%0d complete headers, %0d zero frame, %0d error or truncated, %0d output hold-offs",
             board.status_hits[ST_OK], board.status_hits[ST_ZERO_FRAME],
             board.results_checked - board.status_hits[ST_OK] - board.status_hits[ST_ZERO_FRAME],
             holds_done);
    if (board.mismatches == 0) begin
      $display("wav_header_parser verification clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("wav_header_parser verification failed");
    end
    $finish;
  end

endmodule
